// ===== hw/rtl/sfvs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sfvs_pkg;

    localparam int FACTOR_W      = 62;
    localparam int BASE_W        = 32;
    localparam int COUNT_W       = 14;
    localparam int CFG_ADDR_W    = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int MUL_CNT_W     = 6;
    localparam int BASE_SPAN_DEF = 4096;
    localparam int EXP_BITS_DEF  = 32;

    localparam logic [COUNT_W-1:0]  COUNT_MAX      = '1;
    localparam logic [FACTOR_W-1:0] K_RESET        = 62'd2;
    localparam logic [BASE_W-1:0]   BASE_MIN_RESET = 32'd2;
    localparam logic [BASE_W-1:0]   BASE_MAX_RESET = 32'd4097;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_K        = 2'd0,
        REG_BASE_MIN = 2'd1,
        REG_BASE_MAX = 2'd2
    } cfg_reg_t;

    // operand selection for the shared modular multiplier
    typedef enum logic [2:0] {
        MS_BASE,
        MS_K,
        MS_SQR,
        MS_X,
        MS_FIN
    } mul_sel_t;

    typedef struct packed {
        logic     load;
        logic     r_init;
        logic     mul_start;
        mul_sel_t sel;
        logic     exp_shift;
    } dp_cmd_t;

    typedef struct packed {
        logic oow;
        logic p_small;
        logic mul_done;
        logic e_bit;
        logic match;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sfvs_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface sfvs_item_if;
    import sfvs_pkg::*;
    logic                valid;
    logic                ready;
    logic [FACTOR_W-1:0] factor;
    logic [BASE_W-1:0]   base;
    logic                minus_form;
    modport source (output valid, factor, base, minus_form, input ready);
    modport sink (input valid, factor, base, minus_form, output ready);
endinterface

interface sfvs_result_if;
    import sfvs_pkg::*;
    logic               valid;
    logic               ready;
    logic               removed;
    logic               out_of_window;
    logic               not_a_factor;
    logic [COUNT_W-1:0] total_removed;
    modport source (output valid, removed, out_of_window, not_a_factor, total_removed,
                    input ready);
    modport sink (input valid, removed, out_of_window, not_a_factor, total_removed,
                  output ready);
endinterface

interface sfvs_cfg_if;
    import sfvs_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
    modport source (output valid, addr, wdata, input ready);
    modport sink (input valid, addr, wdata, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sieve_factor_verify_and_strike.sv =====
// Channel  Dir  Fields                                           Transfer
// item     in   factor[61:0] base[31:0] minus_form               valid & ready
// result   out  removed out_of_window not_a_factor total[13:0]   valid & ready
// cfg      in   addr[1:0] wdata[63:0]                            valid & ready (ready = 1)
//
// One item at a time. An out-of-window base or a factor below two skips the multiplier.
// A full check runs up to 3 + 2*EXP_BITS modular products on one bit-serial
// multiplier, one product at a time.
// After reset every entry of the alive bitmap is set to 11; item.ready stays low until then.
// A result waits in the output register; the next item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module sieve_factor_verify_and_strike #(
    parameter int BASE_SPAN = sfvs_pkg::BASE_SPAN_DEF,
    parameter int EXP_BITS  = sfvs_pkg::EXP_BITS_DEF
) (
    input wire logic      clk,
    input wire logic      rst_n,
    sfvs_item_if.sink     item,
    sfvs_result_if.source result,
    sfvs_cfg_if.sink      cfg
);
    import sfvs_pkg::*;

    localparam int IDX_W = $clog2(BASE_SPAN);

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [IDX_W-1:0] idx;
    logic             minus;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [1:0]       ram_wdata;
    logic [1:0]       ram_rdata;

    assign cfg.ready = 1'b1;

    sfvs_ctrl #(
        .BASE_SPAN (BASE_SPAN),
        .EXP_BITS  (EXP_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (item.valid),
        .in_ready      (item.ready),
        .out_valid     (result.valid),
        .out_ready     (result.ready),
        .removed       (result.removed),
        .out_of_window (result.out_of_window),
        .not_a_factor  (result.not_a_factor),
        .total_removed (result.total_removed),
        .cmd           (cmd),
        .stat          (stat),
        .minus         (minus),
        .idx           (idx),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_rdata     (ram_rdata)
    );

    sfvs_dp #(
        .BASE_SPAN (BASE_SPAN),
        .EXP_BITS  (EXP_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .factor     (item.factor),
        .base       (item.base),
        .minus_form (item.minus_form),
        .cfg_we     (cfg.valid),
        .cfg_addr   (cfg.addr),
        .cfg_wdata  (cfg.wdata),
        .idx        (idx),
        .minus      (minus)
    );

    // bit 0: plus form alive, bit 1: minus form alive
    sfvs_ram #(
        .WIDTH (2),
        .DEPTH (BASE_SPAN)
    ) u_alive_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx),
        .rdata (ram_rdata)
    );

endmodule
`default_nettype wire

// ===== hw/rtl/sfvs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sfvs_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/sfvs_modmul.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sfvs_modmul (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [sfvs_pkg::FACTOR_W-1:0] a,
    input  wire logic [sfvs_pkg::FACTOR_W-1:0] b,
    input  wire logic [sfvs_pkg::FACTOR_W-1:0] p,
    output logic                               done,
    output logic      [sfvs_pkg::FACTOR_W-1:0] prod
);
    import sfvs_pkg::*;

    logic [FACTOR_W-1:0]  a_reg;
    logic [FACTOR_W-1:0]  b_reg;
    logic [FACTOR_W-1:0]  acc_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [FACTOR_W:0]    dbl;
    logic [FACTOR_W:0]    dbl_red;
    logic [FACTOR_W:0]    sum;
    logic [FACTOR_W:0]    sum_red;

    // one multiplier bit per cycle, msb first: acc = 2*acc + bit*a, mod p
    always_comb
    begin
        dbl     = {acc_reg, 1'b0};
        dbl_red = (dbl >= {1'b0, p}) ? dbl - {1'b0, p} : dbl;
        sum     = dbl_red + (b_reg[FACTOR_W-1] ? {1'b0, a_reg} : '0);
        sum_red = (sum >= {1'b0, p}) ? sum - {1'b0, p} : sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MUL_CNT_W'(FACTOR_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= sum_red[FACTOR_W-1:0];
            b_reg   <= b_reg << 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/sfvs_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sfvs_dp #(
    parameter int BASE_SPAN = sfvs_pkg::BASE_SPAN_DEF,
    parameter int EXP_BITS  = sfvs_pkg::EXP_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire sfvs_pkg::dp_cmd_t               cmd,
    output sfvs_pkg::dp_stat_t                   stat,
    input  wire logic [sfvs_pkg::FACTOR_W-1:0]   factor,
    input  wire logic [sfvs_pkg::BASE_W-1:0]     base,
    input  wire logic                            minus_form,
    input  wire logic                            cfg_we,
    input  wire logic [sfvs_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [sfvs_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic      [$clog2(BASE_SPAN)-1:0]    idx,
    output logic                                 minus
);
    import sfvs_pkg::*;

    localparam int IDX_W = $clog2(BASE_SPAN);

    logic [FACTOR_W-1:0] k_reg;
    logic [BASE_W-1:0]   base_min_reg;
    logic [BASE_W-1:0]   base_max_reg;
    logic [FACTOR_W-1:0] p_reg;
    logic [BASE_W-1:0]   base_reg;
    logic                minus_reg;
    logic [EXP_BITS-1:0] exp_reg;
    logic [FACTOR_W-1:0] xr_reg;
    logic [FACTOR_W-1:0] kr_reg;
    logic [FACTOR_W-1:0] r_reg;
    mul_sel_t            sel_reg;
    logic [FACTOR_W-1:0] mul_a;
    logic [FACTOR_W-1:0] mul_b;
    logic [FACTOR_W-1:0] prod;
    logic                mul_done;
    logic [BASE_W:0]     diff;
    logic [FACTOR_W-1:0] target;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg        <= K_RESET;
            base_min_reg <= BASE_MIN_RESET;
            base_max_reg <= BASE_MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_K:        k_reg        <= cfg_wdata[FACTOR_W-1:0];
                REG_BASE_MIN: base_min_reg <= cfg_wdata[BASE_W-1:0];
                REG_BASE_MAX: base_max_reg <= cfg_wdata[BASE_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cmd.sel)
            MS_BASE:
            begin
                mul_a = FACTOR_W'(1);
                mul_b = {{(FACTOR_W-BASE_W){1'b0}}, base_reg};
            end
            MS_K:
            begin
                mul_a = FACTOR_W'(1);
                mul_b = k_reg;
            end
            MS_SQR:
            begin
                mul_a = r_reg;
                mul_b = r_reg;
            end
            MS_X:
            begin
                mul_a = r_reg;
                mul_b = xr_reg;
            end
            MS_FIN:
            begin
                mul_a = r_reg;
                mul_b = kr_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // operand select is latched with the start command and held for the whole run
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= MS_BASE;
        end
        else if (cmd.mul_start)
        begin
            sel_reg <= cmd.sel;
        end
    end

    sfvs_modmul u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .p     (p_reg),
        .done  (mul_done),
        .prod  (prod)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            p_reg     <= factor;
            base_reg  <= base;
            minus_reg <= minus_form;
            exp_reg   <= base[EXP_BITS-1:0];
        end
        else if (cmd.exp_shift)
        begin
            exp_reg <= exp_reg << 1;
        end

        if (cmd.r_init)
        begin
            r_reg <= FACTOR_W'(1);
        end
        else if (mul_done)
        begin
            unique case (sel_reg)
                MS_BASE: xr_reg <= prod;
                MS_K:    kr_reg <= prod;
                default: r_reg  <= prod;
            endcase
        end
    end

    always_comb
    begin
        diff   = {1'b0, base_reg} - {1'b0, base_min_reg};
        target = minus_reg ? FACTOR_W'(1) : p_reg - 1'b1;
        stat.oow = (base_reg < base_min_reg) || (base_reg > base_max_reg)
                   || (diff >= (BASE_W+1)'(BASE_SPAN));
        stat.p_small  = (p_reg < FACTOR_W'(2));
        stat.mul_done = mul_done;
        stat.e_bit    = exp_reg[EXP_BITS-1];
        stat.match    = (r_reg == target);
    end

    assign idx   = diff[IDX_W-1:0];
    assign minus = minus_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/sfvs_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sfvs_ctrl #(
    parameter int BASE_SPAN = sfvs_pkg::BASE_SPAN_DEF,
    parameter int EXP_BITS  = sfvs_pkg::EXP_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic                              removed,
    output logic                              out_of_window,
    output logic                              not_a_factor,
    output logic [sfvs_pkg::COUNT_W-1:0]      total_removed,
    output sfvs_pkg::dp_cmd_t                 cmd,
    input  wire sfvs_pkg::dp_stat_t           stat,
    input  wire logic                         minus,
    input  wire logic [$clog2(BASE_SPAN)-1:0] idx,
    output logic                              ram_we,
    output logic      [$clog2(BASE_SPAN)-1:0] ram_waddr,
    output logic      [1:0]                   ram_wdata,
    input  wire logic [1:0]                   ram_rdata
);
    import sfvs_pkg::*;

    localparam int IDX_W = $clog2(BASE_SPAN);
    localparam int BIT_W = $clog2(EXP_BITS);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_GO,
        ST_WAIT,
        ST_TEST,
        ST_STRIKE,
        ST_DONE
    } state_t;

    state_t             state_reg;
    mul_sel_t           sel_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic [IDX_W-1:0]   clr_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               pend_removed_reg;
    logic               pend_oow_reg;
    logic               pend_naf_reg;
    logic               out_valid_reg;
    logic               removed_reg;
    logic               oow_reg;
    logic               naf_reg;
    logic [COUNT_W-1:0] total_reg;
    logic               last_bit;
    logic               next_bit;
    logic               alive;
    logic               out_free;

    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        last_bit      = (bit_reg == '0);
        next_bit      = (state_reg == ST_WAIT) && stat.mul_done
                        && (((sel_reg == MS_SQR) && !stat.e_bit) || (sel_reg == MS_X));
        cmd.load      = in_valid && in_ready;
        cmd.r_init    = (state_reg == ST_CHECK);
        cmd.mul_start = (state_reg == ST_GO);
        cmd.sel       = sel_reg;
        cmd.exp_shift = next_bit && !last_bit;
        alive         = minus ? ram_rdata[1] : ram_rdata[0];
        out_free      = !out_valid_reg || out_ready;
        ram_we        = (state_reg == ST_CLEAR) || ((state_reg == ST_STRIKE) && alive);
        ram_waddr     = (state_reg == ST_CLEAR) ? clr_reg : idx;
        if (state_reg == ST_CLEAR)
        begin
            ram_wdata = 2'b11;
        end
        else
        begin
            ram_wdata = minus ? {1'b0, ram_rdata[0]} : {ram_rdata[1], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            sel_reg          <= MS_BASE;
            bit_reg          <= '0;
            clr_reg          <= '0;
            count_reg        <= '0;
            pend_removed_reg <= 1'b0;
            pend_oow_reg     <= 1'b0;
            pend_naf_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            removed_reg      <= 1'b0;
            oow_reg          <= 1'b0;
            naf_reg          <= 1'b0;
            total_reg        <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == IDX_W'(BASE_SPAN - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= ST_CHECK;
                    end
                end
                ST_CHECK:
                begin
                    pend_removed_reg <= 1'b0;
                    pend_oow_reg     <= stat.oow;
                    pend_naf_reg     <= !stat.oow && stat.p_small;
                    sel_reg          <= MS_BASE;
                    bit_reg          <= BIT_W'(EXP_BITS - 1);
                    if (stat.oow || stat.p_small)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_GO;
                    end
                end
                ST_GO:
                begin
                    state_reg <= ST_WAIT;
                end
                ST_WAIT:
                begin
                    if (stat.mul_done)
                    begin
                        priority if (sel_reg == MS_FIN)
                        begin
                            state_reg <= ST_TEST;
                        end
                        else
                        begin
                            state_reg <= ST_GO;
                            priority if (next_bit)
                            begin
                                if (last_bit)
                                begin
                                    sel_reg <= MS_FIN;
                                end
                                else
                                begin
                                    sel_reg <= MS_SQR;
                                    bit_reg <= bit_reg - 1'b1;
                                end
                            end
                            else if (sel_reg == MS_BASE)
                            begin
                                sel_reg <= MS_K;
                            end
                            else if (sel_reg == MS_K)
                            begin
                                sel_reg <= MS_SQR;
                            end
                            else
                            begin
                                sel_reg <= MS_X;
                            end
                        end
                    end
                end
                ST_TEST:
                begin
                    if (stat.match)
                    begin
                        state_reg <= ST_STRIKE;
                    end
                    else
                    begin
                        pend_naf_reg <= 1'b1;
                        state_reg    <= ST_DONE;
                    end
                end
                ST_STRIKE:
                begin
                    if (alive)
                    begin
                        pend_removed_reg <= 1'b1;
                        if (count_reg != COUNT_MAX)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        removed_reg   <= pend_removed_reg;
                        oow_reg       <= pend_oow_reg;
                        naf_reg       <= pend_naf_reg;
                        total_reg     <= count_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign removed       = removed_reg;
    assign out_of_window = oow_reg;
    assign not_a_factor  = naf_reg;
    assign total_removed = total_reg;

endmodule
`default_nettype wire

// ===== hw/rtl/sfvs_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sfvs_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         item_valid,
    input wire logic                         item_ready,
    input wire logic                         result_valid,
    input wire logic                         result_ready,
    input wire logic                         removed,
    input wire logic                         out_of_window,
    input wire logic                         not_a_factor,
    input wire logic [sfvs_pkg::COUNT_W-1:0] total_removed
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped before transfer");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $countones({removed, out_of_window, not_a_factor}) <= 1)
        else $error("more than one outcome flag set");

    a_strike_counted: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && removed |-> total_removed != '0)
        else $error("strike reported with zero count");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("second item taken while busy");

endmodule

bind sieve_factor_verify_and_strike sfvs_checker u_sfvs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item.valid),
    .item_ready    (item.ready),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .removed       (result.removed),
    .out_of_window (result.out_of_window),
    .not_a_factor  (result.not_a_factor),
    .total_removed (result.total_removed)
);
`default_nettype wire
